// ===== design/bpfa_pkg.sv =====
package bpfa_pkg;

	// fixed field widths
	localparam int CNT_W  = 13;
	localparam int PAGE_W = 12;
	localparam int KIND_W = 3;
	localparam int WORD_W = 32;
	localparam int OFF_W  = 5;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam int NUM_PAGES_DEF = 4096;
	localparam logic [CNT_W-1:0] TOTAL_RESET = 13'h1000;

	// register index
	localparam logic [0:0] REG_TOTAL = 1'b0;

	// request codes
	localparam logic [KIND_W-1:0] REQ_ALLOC     = 3'd0;
	localparam logic [KIND_W-1:0] REQ_FREE      = 3'd1;
	localparam logic [KIND_W-1:0] REQ_LOCK      = 3'd2;
	localparam logic [KIND_W-1:0] REQ_RESERVE   = 3'd3;
	localparam logic [KIND_W-1:0] REQ_UNRESERVE = 3'd4;

	typedef struct packed {
		logic accept;
		logic clr_start;
		logic clr_step;
		logic rd;
		logic a_hit;
		logic a_next;
		logic a_fail;
		logic ld_word;
		logic walk;
		logic wb_end;
		logic ld_out;
	} cmd_t;

	typedef struct packed {
		logic run_end;
		logic word_last;
		logic a_over;
		logic a_hit;
		logic clr_last;
	} sts_t;

endpackage

// ===== design/bpfa_ctrl.sv =====
module bpfa_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           in_valid,
	input  logic [bpfa_pkg::KIND_W-1:0]    req_type,
	output logic                           in_stall,
	output logic                           out_valid,
	input  logic                           out_stall,
	input  bpfa_pkg::sts_t                 sts,
	output bpfa_pkg::cmd_t                 cmd
);
	import bpfa_pkg::*;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_ARD  = 3'd2;
	localparam logic [2:0] S_ACHK = 3'd3;
	localparam logic [2:0] S_RRD  = 3'd4;
	localparam logic [2:0] S_RLD  = 3'd5;
	localparam logic [2:0] S_WALK = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (req_type == REQ_ALLOC) begin
						state_d = S_ARD;
					end else if (req_type inside {[REQ_FREE:REQ_UNRESERVE]}) begin
						state_d = S_RRD;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_ARD: begin
				if (sts.a_over) begin
					cmd.a_fail = 1'b1;
					state_d    = S_FIN;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_ACHK;
				end
			end
			S_ACHK: begin
				if (sts.a_hit) begin
					cmd.a_hit = 1'b1;
					state_d   = S_FIN;
				end else begin
					cmd.a_next = 1'b1;
					state_d    = S_ARD;
				end
			end
			S_RRD: begin
				if (sts.run_end) begin
					state_d = S_FIN;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_RLD;
				end
			end
			S_RLD: begin
				cmd.ld_word = 1'b1;
				state_d     = S_WALK;
			end
			S_WALK: begin
				if (sts.run_end) begin
					cmd.wb_end = 1'b1;
					state_d    = S_FIN;
				end else begin
					cmd.walk = 1'b1;
					if (sts.word_last) begin
						state_d = S_RRD;
					end
				end
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.ld_out = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLR;
			end
		endcase
		if (cfg_we) begin
			cmd           = '0;
			cmd.clr_start = 1'b1;
			state_d       = S_CLR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/bpfa_dp.sv =====
module bpfa_dp #(
	parameter int NUM_PAGES = bpfa_pkg::NUM_PAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpfa_pkg::CNT_W-1:0]     cfg_value,
	output logic [bpfa_pkg::CNT_W-1:0]     total_pages,
	input  logic [bpfa_pkg::KIND_W-1:0]    req_type,
	input  logic [bpfa_pkg::PAGE_W-1:0]    start_page,
	input  logic [bpfa_pkg::CNT_W-1:0]     page_count,
	output logic                           status,
	output logic [bpfa_pkg::PAGE_W-1:0]    page_number,
	output logic [bpfa_pkg::CNT_W-1:0]     pages_changed,
	output logic [bpfa_pkg::CNT_W-1:0]     free_pages,
	output logic [bpfa_pkg::CNT_W-1:0]     used_pages,
	output logic [bpfa_pkg::CNT_W-1:0]     reserved_pages,
	input  bpfa_pkg::cmd_t                 cmd,
	output bpfa_pkg::sts_t                 sts
);
	import bpfa_pkg::*;

	localparam int MAP_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int PW        = $clog2(NUM_PAGES);
	localparam int PTR_W     = ((PW > CNT_W) ? PW : CNT_W) + 1;
	localparam logic [PTR_W-1:0] NUM_LIM   = PTR_W'(NUM_PAGES);
	localparam logic [AW-1:0]    LAST_WORD = AW'(MAP_WORDS - 1);

	logic [WORD_W-1:0] mem [MAP_WORDS];
	logic [WORD_W-1:0] rdata_q, wd_q, wd_nxt, wr_data;
	logic [AW-1:0]     clr_q, wr_addr, word_idx;
	logic              we;

	logic [CNT_W-1:0]  tot_q, free_q, used_q, rsv_q;
	logic [PTR_W-1:0]  ptr_q, lim, cand;
	logic [CNT_W-1:0]  cnt_q, changed_q;
	logic [KIND_W-1:0] kind_q;
	logic [PAGE_W-1:0] granted_q;
	logic              stat_q;

	logic              zero_hit, target, flip;
	logic [OFF_W-1:0]  zero_idx, off;

	logic              out_stat_q;
	logic [PAGE_W-1:0] out_page_q;
	logic [CNT_W-1:0]  out_chg_q, out_free_q, out_used_q, out_rsv_q;

	assign lim      = (PTR_W'(tot_q) < NUM_LIM) ? PTR_W'(tot_q) : NUM_LIM;
	assign word_idx = ptr_q[OFF_W +: AW];
	assign off      = ptr_q[OFF_W-1:0];

	// lowest clear bit of the fetched word
	always_comb begin
		zero_hit = 1'b0;
		zero_idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!rdata_q[i]) begin
				zero_hit = 1'b1;
				zero_idx = OFF_W'(i);
			end
		end
	end

	assign cand   = ptr_q + PTR_W'(zero_idx);
	assign target = (kind_q == REQ_LOCK) || (kind_q == REQ_RESERVE);
	assign flip   = (wd_q[off] != target);

	always_comb begin
		wd_nxt      = wd_q;
		wd_nxt[off] = target;
	end

	always_comb begin
		if (cmd.clr_step) begin
			wr_data = '0;
		end else if (cmd.a_hit) begin
			wr_data = rdata_q | (WORD_W'(1) << zero_idx);
		end else if (cmd.wb_end) begin
			wr_data = wd_q;
		end else begin
			wr_data = wd_nxt;
		end
	end

	assign wr_addr = cmd.clr_step ? clr_q : word_idx;
	assign we      = cmd.clr_step | cmd.a_hit | cmd.wb_end | (cmd.walk & sts.word_last);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rdata_q <= mem[word_idx];
		end
	end

	assign sts.run_end   = (cnt_q == '0) || (ptr_q >= lim);
	assign sts.word_last = &off;
	assign sts.a_over    = (ptr_q >= lim);
	assign sts.a_hit     = zero_hit && (cand < lim);
	assign sts.clr_last  = (clr_q == LAST_WORD);

	// configuration and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q  <= TOTAL_RESET;
			free_q <= TOTAL_RESET;
			used_q <= '0;
			rsv_q  <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.clr_start) begin
				clr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_we) begin
				tot_q  <= cfg_value;
				free_q <= cfg_value;
				used_q <= '0;
				rsv_q  <= '0;
			end else if (cmd.a_hit) begin
				free_q <= free_q - CNT_W'(1);
				used_q <= used_q + CNT_W'(1);
			end else if (cmd.walk && flip) begin
				free_q <= target ? (free_q - CNT_W'(1)) : (free_q + CNT_W'(1));
				case (kind_q)
					REQ_FREE:      used_q <= used_q - CNT_W'(1);
					REQ_LOCK:      used_q <= used_q + CNT_W'(1);
					REQ_RESERVE:   rsv_q  <= rsv_q + CNT_W'(1);
					REQ_UNRESERVE: rsv_q  <= rsv_q - CNT_W'(1);
					default:       used_q <= used_q;
				endcase
			end
		end
	end

	// request working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q    <= req_type;
			ptr_q     <= (req_type == REQ_ALLOC) ? '0 : PTR_W'(start_page);
			cnt_q     <= page_count;
			changed_q <= '0;
			granted_q <= '0;
			stat_q    <= 1'b0;
		end
		if (cmd.a_next) begin
			ptr_q <= ptr_q + PTR_W'(WORD_W);
		end
		if (cmd.a_hit) begin
			granted_q <= cand[PAGE_W-1:0];
			changed_q <= CNT_W'(1);
		end
		if (cmd.a_fail) begin
			stat_q <= 1'b1;
		end
		if (cmd.ld_word) begin
			wd_q <= rdata_q;
		end
		if (cmd.walk) begin
			wd_q  <= wd_nxt;
			ptr_q <= ptr_q + PTR_W'(1);
			cnt_q <= cnt_q - CNT_W'(1);
			if (flip) begin
				changed_q <= changed_q + CNT_W'(1);
			end
		end
		if (cmd.ld_out) begin
			out_stat_q <= stat_q;
			out_page_q <= granted_q;
			out_chg_q  <= changed_q;
			out_free_q <= free_q;
			out_used_q <= used_q;
			out_rsv_q  <= rsv_q;
		end
	end

	assign total_pages    = tot_q;
	assign status         = out_stat_q;
	assign page_number    = out_page_q;
	assign pages_changed  = out_chg_q;
	assign free_pages     = out_free_q;
	assign used_pages     = out_used_q;
	assign reserved_pages = out_rsv_q;

endmodule

// ===== design/bitmap_page_frame_allocator_unit.sv =====
// allocate scans the map word by word for the lowest clear bit below the page limit;
// free, lock, reserve and unreserve runs walk page by page, reading and writing back each map
// word touched; unknown codes go straight to the result; one item at a time, and the single-port
// usage map and its read register set the pace; async reset loads total_pages and the free
// count with 4096 and clears the used and reserved counts, then a clearing pass zeroes the
// map one word a cycle, input stalled; a total_pages write reruns it
module bitmap_page_frame_allocator_unit #(
	parameter int NUM_PAGES = bpfa_pkg::NUM_PAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bpfa_pkg::ADDR_W-1:0]    paddr,
	input  logic [bpfa_pkg::DATA_W-1:0]    pwdata,
	output logic [bpfa_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	// request items
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [bpfa_pkg::KIND_W-1:0]    req_type,
	input  logic [bpfa_pkg::PAGE_W-1:0]    start_page,
	input  logic [bpfa_pkg::CNT_W-1:0]     page_count,
	// result items
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           status,
	output logic [bpfa_pkg::PAGE_W-1:0]    page_number,
	output logic [bpfa_pkg::CNT_W-1:0]     pages_changed,
	output logic [bpfa_pkg::CNT_W-1:0]     free_pages,
	output logic [bpfa_pkg::CNT_W-1:0]     used_pages,
	output logic [bpfa_pkg::CNT_W-1:0]     reserved_pages
);
	import bpfa_pkg::*;

	cmd_t             cmd;
	sts_t             sts;
	logic             cfg_we;
	logic             reg_sel;
	logic [CNT_W-1:0] total_pages;

	// one register, word addressed; the index bit decodes it
	assign reg_sel = (paddr[ADDR_W-1:2] == REG_TOTAL);
	assign cfg_we  = psel && penable && pwrite && reg_sel;
	assign pready  = 1'b1;
	// read back total_pages, zero elsewhere
	assign prdata  = reg_sel ? DATA_W'(total_pages) : '0;

	// sequencer: clearing pass, word scan for allocate, page walk for runs
	bpfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.in_valid  (in_valid),
		.req_type  (req_type),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// usage map memory, counters, page pointer and result register
	bpfa_dp #(
		.NUM_PAGES (NUM_PAGES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_value      (pwdata[CNT_W-1:0]),
		.total_pages    (total_pages),
		.req_type       (req_type),
		.start_page     (start_page),
		.page_count     (page_count),
		.status         (status),
		.page_number    (page_number),
		.pages_changed  (pages_changed),
		.free_pages     (free_pages),
		.used_pages     (used_pages),
		.reserved_pages (reserved_pages),
		.cmd            (cmd),
		.sts            (sts)
	);

endmodule
